FILE: design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Antecedent at one edge implies consequent at the next edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: design/lrb_pkg.sv
// ----------------------------------------------------------------------------
// lrb_pkg
// Types and codes of the link reconnect backoff supervisor.
// ----------------------------------------------------------------------------
package lrb_pkg;

   // operation codes
   localparam logic [2:0] OP_TICK       = 3'd0;
   localparam logic [2:0] OP_SOCK_OPEN  = 3'd1;
   localparam logic [2:0] OP_REG_ACK    = 3'd2;
   localparam logic [2:0] OP_TRAFFIC    = 3'd3;
   localparam logic [2:0] OP_RETRY      = 3'd4;
   localparam logic [2:0] OP_NET_RESET  = 3'd5;
   localparam logic [2:0] OP_CFG_SAVED  = 3'd6;

   // connection states
   localparam logic [2:0] MODE_IDLE       = 3'd0;
   localparam logic [2:0] MODE_CONNECTING = 3'd1;
   localparam logic [2:0] MODE_CONNECTED  = 3'd2;
   localparam logic [2:0] MODE_REGISTERED = 3'd3;
   localparam logic [2:0] MODE_FAILED     = 3'd4;

   // event codes
   localparam logic [2:0] EV_NONE         = 3'd0;
   localparam logic [2:0] EV_CONNECTED    = 3'd1;
   localparam logic [2:0] EV_DISCONNECTED = 3'd2;
   localparam logic [2:0] EV_REGISTERED   = 3'd3;
   localparam logic [2:0] EV_FAILED       = 3'd4;
   localparam logic [2:0] EV_COMMAND      = 3'd5;

   // register indexes
   localparam logic [2:0] CSR_CONNECT_TIMEOUT = 3'd0;
   localparam logic [2:0] CSR_MAX_ATTEMPTS    = 3'd1;
   localparam logic [2:0] CSR_BACKOFF_BASE    = 3'd2;
   localparam logic [2:0] CSR_BACKOFF_CAP     = 3'd3;
   localparam logic [2:0] CSR_HB_INTERVAL     = 3'd4;

   localparam logic [31:0] CONNECT_TIMEOUT_RST = 32'd10000;
   localparam logic [7:0]  MAX_ATTEMPTS_RST    = 8'd5;
   localparam logic [31:0] BACKOFF_BASE_RST    = 32'd1000;
   localparam logic [31:0] BACKOFF_CAP_RST     = 32'd30000;
   localparam logic [31:0] HB_INTERVAL_RST     = 32'd30000;

   typedef struct packed {
      logic [2:0]  operation;
      logic [31:0] now_ms;
      logic        link_up;
      logic        config_present;
   } req_type;

   typedef struct packed {
      logic [2:0] conn_state;
      logic [7:0] attempt_count;
      logic [2:0] event_code;
      logic       start_connect;
      logic       send_register;
      logic       send_heartbeat;
      logic       close_socket;
      logic       may_send;
   } rsp_type;

endpackage

FILE: design/link_reconnect_backoff_fsm_unit.sv
// ----------------------------------------------------------------------------
// link_reconnect_backoff_fsm_unit
// Connection supervisor with connect timeout and capped exponential backoff.
// ----------------------------------------------------------------------------
// Each request is one classified event (tick, socket opened, registration
// ack, traffic, manual retry, network reset, config saved) with the current
// millisecond time; each yields exactly one response with the new state,
// attempt count, event code and action flags. A request is registered on
// entry, the state update is combinational from that register, and the
// response is registered at the output and held while rsp_ready is low.
// One request is taken every cycle while no response is stalled; the clock
// rate is set by the single next-state pass (backoff shift, compare and
// deadline add). The user must write configuration registers through the
// csr_ port only while no request is pending; the block does not enforce it.
module link_reconnect_backoff_fsm_unit
   import lrb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   // configuration
   logic [31:0] timeout_ff, base_ff, cap_ff, hb_int_ff;
   logic [7:0]  max_att_ff;

   // input and output stages
   logic    in_valid_ff, rsp_valid_ff;
   req_type in_ff;
   rsp_type rsp_ff, rsp_in;
   logic    advance;

   // supervisor state
   logic [2:0]  mode_ff, mode_in;
   logic [7:0]  attempts_ff, attempts_in;
   logic        in_flight_ff, in_flight_in;
   logic [31:0] deadline_ff, deadline_in;
   logic [31:0] start_ff, start_in;
   logic [31:0] last_hb_ff, last_hb_in;

   // helpers
   logic [7:0]  att_bump;
   logic [63:0] shifted;
   logic        delay_big;
   logic [31:0] delay;
   logic [31:0] retry_at;
   logic        att_fail;
   logic        timed_out;
   logic        hb_due;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= CONNECT_TIMEOUT_RST;
         max_att_ff <= MAX_ATTEMPTS_RST;
         base_ff    <= BACKOFF_BASE_RST;
         cap_ff     <= BACKOFF_CAP_RST;
         hb_int_ff  <= HB_INTERVAL_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CONNECT_TIMEOUT: timeout_ff <= csr_wdata;
            CSR_MAX_ATTEMPTS:    max_att_ff <= csr_wdata[7:0];
            CSR_BACKOFF_BASE:    base_ff    <= csr_wdata;
            CSR_BACKOFF_CAP:     cap_ff     <= csr_wdata;
            CSR_HB_INTERVAL:     hb_int_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // saturating bump and the backoff delay for the bumped count
   assign att_bump = (attempts_ff == 8'hFF) ? attempts_ff : attempts_ff + 8'd1;
   assign shifted  = {32'd0, base_ff} << att_bump[4:0];
   assign delay_big = ((att_bump[7:5] != 3'd0) && (base_ff != 32'd0))
                      || (shifted >= {32'd0, cap_ff});
   assign delay     = delay_big ? cap_ff : shifted[31:0];
   assign retry_at  = in_ff.now_ms + delay;
   assign att_fail  = att_bump >= max_att_ff;
   assign timed_out = (in_ff.now_ms - start_ff) >= timeout_ff;
   assign hb_due    = (in_ff.now_ms - last_hb_ff) > hb_int_ff;

   always_comb begin
      mode_in      = mode_ff;
      attempts_in  = attempts_ff;
      in_flight_in = in_flight_ff;
      deadline_in  = deadline_ff;
      start_in     = start_ff;
      last_hb_in   = last_hb_ff;
      rsp_in       = '0;
      rsp_in.event_code = EV_NONE;

      unique case (in_ff.operation)
         OP_TICK: begin
            unique case (mode_ff)
               MODE_IDLE: begin
                  if (in_ff.config_present) begin
                     mode_in      = MODE_CONNECTING;
                     in_flight_in = 1'b0;
                     deadline_in  = '0;
                  end
               end
               MODE_CONNECTING: begin
                  // sit out the backoff, then time out or launch
                  if (in_ff.now_ms < deadline_ff) begin
                     mode_in = mode_ff;
                  end else if (in_flight_ff) begin
                     if (timed_out) begin
                        in_flight_in = 1'b0;
                        attempts_in  = att_bump;
                        if (att_fail) begin
                           mode_in             = MODE_FAILED;
                           rsp_in.close_socket = in_ff.link_up;
                           rsp_in.event_code   = EV_FAILED;
                        end else begin
                           deadline_in = retry_at;
                        end
                     end
                  end else begin
                     start_in             = in_ff.now_ms;
                     in_flight_in         = 1'b1;
                     rsp_in.start_connect = 1'b1;
                  end
               end
               MODE_CONNECTED: begin
                  if (!in_ff.link_up) begin
                     attempts_in  = att_bump;
                     in_flight_in = 1'b0;
                     if (att_fail) begin
                        mode_in           = MODE_FAILED;
                        rsp_in.event_code = EV_FAILED;
                     end else begin
                        deadline_in       = retry_at;
                        mode_in           = MODE_CONNECTING;
                        rsp_in.event_code = EV_DISCONNECTED;
                     end
                  end
               end
               MODE_REGISTERED: begin
                  if (in_ff.link_up) begin
                     if (hb_due) begin
                        last_hb_in            = in_ff.now_ms;
                        rsp_in.send_heartbeat = 1'b1;
                     end
                  end else begin
                     attempts_in       = '0;
                     in_flight_in      = 1'b0;
                     deadline_in       = '0;
                     mode_in           = MODE_CONNECTING;
                     rsp_in.event_code = EV_DISCONNECTED;
                  end
               end
               default: ;
            endcase
         end
         OP_SOCK_OPEN: begin
            mode_in              = MODE_CONNECTED;
            in_flight_in         = 1'b0;
            attempts_in          = '0;
            rsp_in.event_code    = EV_CONNECTED;
            rsp_in.send_register = 1'b1;
         end
         OP_REG_ACK: begin
            mode_in           = MODE_REGISTERED;
            attempts_in       = '0;
            last_hb_in        = in_ff.now_ms;
            rsp_in.event_code = EV_REGISTERED;
         end
         OP_TRAFFIC: begin
            last_hb_in        = in_ff.now_ms;
            rsp_in.event_code = EV_COMMAND;
         end
         OP_RETRY: begin
            if (in_ff.config_present) begin
               attempts_in  = '0;
               in_flight_in = 1'b0;
               deadline_in  = '0;
               mode_in      = MODE_CONNECTING;
            end
         end
         OP_NET_RESET: begin
            rsp_in.close_socket = in_ff.link_up;
            mode_in             = MODE_IDLE;
            attempts_in         = '0;
            deadline_in         = '0;
            in_flight_in        = 1'b0;
         end
         OP_CFG_SAVED: begin
            attempts_in  = '0;
            in_flight_in = 1'b0;
            deadline_in  = '0;
            mode_in      = MODE_CONNECTING;
         end
         default: ;
      endcase

      rsp_in.conn_state    = mode_in;
      rsp_in.attempt_count = attempts_in;
      rsp_in.may_send      = (mode_in == MODE_CONNECTED) || (mode_in == MODE_REGISTERED);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= MODE_IDLE;
         attempts_ff  <= '0;
         in_flight_ff <= 1'b0;
         deadline_ff  <= '0;
         start_ff     <= '0;
         last_hb_ff   <= '0;
      end else begin
         if (req_valid && req_ready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            mode_ff      <= mode_in;
            attempts_ff  <= attempts_in;
            in_flight_ff <= in_flight_in;
            deadline_ff  <= deadline_in;
            start_ff     <= start_in;
            last_hb_ff   <= last_hb_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

FILE: design/lrb_checker.sv
// ----------------------------------------------------------------------------
// lrb_checker
// Port-level checks on the link reconnect backoff supervisor.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lrb_checker
   import lrb_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // hold a stalled response
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   `ASSERT_ALWAYS(a_may_send, clock, reset, !rsp_valid || (rsp_data.may_send == ((rsp_data.conn_state == MODE_CONNECTED) || (rsp_data.conn_state == MODE_REGISTERED))))

   `ASSERT_ALWAYS(a_hb_registered, clock, reset, !(rsp_valid && rsp_data.send_heartbeat) || (rsp_data.conn_state == MODE_REGISTERED))

   `ASSERT_ALWAYS(a_start_connecting, clock, reset, !(rsp_valid && rsp_data.start_connect) || (rsp_data.conn_state == MODE_CONNECTING))

   `ASSERT_ALWAYS(a_failed_state, clock, reset, !(rsp_valid && (rsp_data.event_code == EV_FAILED)) || (rsp_data.conn_state == MODE_FAILED))

endmodule

bind link_reconnect_backoff_fsm_unit lrb_checker u_lrb_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
